/* sv/escf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package escf_pkg;

    localparam int unsigned SEQ_MAX = 6;

    localparam logic [2:0] MODE_HTML_Q = 3'd0;
    localparam logic [2:0] MODE_HTML_U = 3'd1;
    localparam logic [2:0] MODE_JS_Q   = 3'd2;
    localparam logic [2:0] MODE_JS_U   = 3'd3;
    localparam logic [2:0] MODE_CSS_Q  = 3'd4;
    localparam logic [2:0] MODE_CSS_U  = 3'd5;
    localparam logic [2:0] MODE_TAG    = 3'd6;

    // escaped form of one input byte, data[0] goes out first
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] data;
        logic [2:0]              cnt;
        logic                    last;
        logic                    empty;
    } seq_t;

endpackage : escf_pkg

`default_nettype wire

/* sv/escf_encode.sv */
`timescale 1ns / 1ps
`default_nettype none

module escf_encode
(
    input  wire logic [2:0]    mode,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output escf_pkg::seq_t     seq
);
    import escf_pkg::*;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = 8'h30 + {4'h0, n};
        else
            c = 8'h37 + {4'h0, n};
        return c;
    endfunction

    // entity string for an html metacharacter, carriage return gives a hard space
    function automatic seq_t entity(input logic [7:0] b);
        seq_t s;
        s = '0;
        case (b)
            "&":
            begin
                s.data[0] = "&"; s.data[1] = "a"; s.data[2] = "m";
                s.data[3] = "p"; s.data[4] = ";"; s.cnt = 3'd5;
            end
            "<":
            begin
                s.data[0] = "&"; s.data[1] = "l"; s.data[2] = "t";
                s.data[3] = ";"; s.cnt = 3'd4;
            end
            ">":
            begin
                s.data[0] = "&"; s.data[1] = "g"; s.data[2] = "t";
                s.data[3] = ";"; s.cnt = 3'd4;
            end
            8'h22:
            begin
                s.data[0] = "&"; s.data[1] = "q"; s.data[2] = "u";
                s.data[3] = "o"; s.data[4] = "t"; s.data[5] = ";";
                s.cnt = 3'd6;
            end
            8'h27:
            begin
                s.data[0] = "&"; s.data[1] = "#"; s.data[2] = "3";
                s.data[3] = "9"; s.data[4] = ";"; s.cnt = 3'd5;
            end
            "=":
            begin
                s.data[0] = "&"; s.data[1] = "#"; s.data[2] = "6";
                s.data[3] = "1"; s.data[4] = ";"; s.cnt = 3'd5;
            end
            default:
            begin
                s.data[0] = "&"; s.data[1] = "n"; s.data[2] = "b";
                s.data[3] = "s"; s.data[4] = "p"; s.data[5] = ";";
                s.cnt = 3'd6;
            end
        endcase
        return s;
    endfunction

    logic [7:0] b;
    logic       html_meta;
    logic       is_alnum;
    logic       is_blank;
    logic       is_ctl;
    logic       html_q_hit;
    logic       html_u_hit;
    logic       js_common;
    logic       js_q_hit;
    logic       js_u_hit;
    logic       css_mark;
    seq_t       s;

    assign b = in_byte;

    always_comb
    begin
        html_meta  = (b == "&") || (b == "<") || (b == ">") || (b == 8'h22) || (b == 8'h27);
        is_alnum   = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
        is_blank   = (b == " ") || (b >= 8'h09 && b <= 8'h0D);
        is_ctl     = (b >= 8'h01 && b <= 8'h08) || (b >= 8'h0E && b <= 8'h1F) || (b == 8'h7F);
        html_q_hit = html_meta || (b == 8'h0D);
        html_u_hit = html_meta || (b == "=");
        // control bytes and delete are escaped in both js modes
        js_common  = html_meta || (b == "/") || (b == 8'h5C) || (b == ";")
                     || (b >= 8'h01 && b <= 8'h1F) || (b == 8'h7F);
        js_q_hit   = js_common;
        js_u_hit   = js_common || (b == "=") || (b == " ");
        css_mark   = (b == "_") || (b == ".") || (b == ",") || (b == "!")
                     || (b == "#") || (b == "%") || (b == "-");

        s         = '0;
        s.data[0] = b;
        s.cnt     = 3'd1;

        case (mode)
            MODE_HTML_Q:
            begin
                if (html_q_hit)
                    s = entity(b);
            end
            MODE_HTML_U:
            begin
                if (is_ctl || is_blank)
                    s.cnt = 3'd0;
                else if (html_u_hit)
                    s = entity(b);
            end
            MODE_JS_Q, MODE_JS_U:
            begin
                if ((mode == MODE_JS_Q) ? js_q_hit : js_u_hit)
                begin
                    s.data[0] = 8'h5C;
                    s.data[1] = "x";
                    s.data[2] = hex_char(b[7:4]);
                    s.data[3] = hex_char(b[3:0]);
                    s.cnt     = 3'd4;
                end
            end
            MODE_CSS_Q, MODE_CSS_U:
            begin
                if (!(is_alnum || css_mark || b[7] || (b == " " && mode == MODE_CSS_Q)))
                    s.cnt = 3'd0;
            end
            MODE_TAG:
            begin
                if (!(is_alnum || b == ":" || b == "_" || b == "-"))
                    s.cnt = 3'd0;
            end
            default:
            begin
                s.cnt = 3'd1;
            end
        endcase

        s.last  = in_last;
        s.empty = 1'b0;
        // a dropped last byte still has to close the string
        if (in_last && s.cnt == 3'd0)
        begin
            s.data[0] = 8'h00;
            s.cnt     = 3'd1;
            s.empty   = 1'b1;
        end
    end

    assign seq = s;

endmodule : escf_encode

`default_nettype wire

/* sv/escf_emit.sv */
`timescale 1ns / 1ps
`default_nettype none

module escf_emit
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire escf_pkg::seq_t load_seq,
    output logic                free,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                out_empty
);
    import escf_pkg::*;

    seq_t       seq_reg;
    logic       valid_reg;
    logic       valid_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       fire;
    logic       at_end;

    assign fire   = valid_reg && !out_stall;
    assign at_end = (idx_reg == seq_reg.cnt - 3'd1);
    assign free   = !valid_reg || (fire && at_end);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
        end
        else if (fire)
        begin
            if (at_end)
                valid_next = 1'b0;
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            seq_reg <= load_seq;
    end

    assign out_valid = valid_reg;
    assign out_byte  = seq_reg.data[idx_reg];
    assign out_last  = seq_reg.last && at_end;
    assign out_empty = seq_reg.empty;

endmodule : escf_emit

`default_nettype wire

/* sv/context_char_escape_filter_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake                     payload
// input     in_valid / in_stall           mode, in_byte, in_last
// output    out_valid / out_stall         out_byte, out_last, out_empty
//
// one input byte is taken every cycle as long as each escapes to one output byte and
// out_stall is low; an escape of more bytes holds the input until the output sequencer,
// which sends one byte per cycle while out_stall is low, has sent them. a dropped byte
// that is not last gives no output byte; the output sequencer registers each escape
// reset clears both valid flags, no clearing pass is needed
// out_stall holds the current byte and backs up into in_stall through the input register

module context_char_escape_filter_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_empty
);
    import escf_pkg::*;

    logic       a_valid_reg;
    logic       a_valid_next;
    logic [2:0] a_mode_reg;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;
    seq_t       a_seq;
    logic       a_drop;
    logic       a_take;
    logic       emit_free;
    logic       emit_load;
    logic       in_fire;

    escf_encode u_encode
    (
        .mode    (a_mode_reg),
        .in_byte (a_byte_reg),
        .in_last (a_last_reg),
        .seq     (a_seq)
    );

    // a dropped byte that closes nothing leaves without a beat
    assign a_drop    = (a_seq.cnt == 3'd0);
    assign a_take    = a_valid_reg && (a_drop || emit_free);
    assign emit_load = a_take && !a_drop;
    assign in_stall  = a_valid_reg && !a_take;
    assign in_fire   = in_valid && !in_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_fire)
            a_valid_next = 1'b1;
        else if (a_take)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_mode_reg <= mode;
            a_byte_reg <= in_byte;
            a_last_reg <= in_last;
        end
    end

    escf_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .load_seq  (a_seq),
        .free      (emit_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_empty (out_empty)
    );

endmodule : context_char_escape_filter_core

`default_nettype wire

/* sim/escape_checker.sv */
`timescale 1ns / 1ps

module escape_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_last,
    input  wire logic       out_empty,
    output int              fail_count,
    output int              beats_due
);

    import escf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } out_beat_t;

    string     hex_digits = "0123456789ABCDEF";
    out_beat_t escaped_due[$];
    out_beat_t seen_due;
    int        mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic bit is_alnum(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic string entity_text(input logic [7:0] b);
        case (b)
            "&":     return "&amp;";
            "<":     return "&lt;";
            ">":     return "&gt;";
            "\"":    return "&quot;";
            "'":     return "&#39;";
            "=":     return "&#61;";
            default: return "&nbsp;";
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        escaped_due.push_back('{data: b, last: 1'b0, empty: 1'b0});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_hex_escape(input logic [7:0] b);
        push_byte("\\");
        push_byte("x");
        push_byte(hex_digits[b[7:4]]);
        push_byte(hex_digits[b[3:0]]);
    endtask

    // expected output beats for one accepted input beat
    task automatic predict_escape(input logic [2:0] m, input logic [7:0] b, input logic l);
        int        first;
        bit        is_ctl;
        out_beat_t tail;
        first  = escaped_due.size();
        is_ctl = (b != 8'h00 && b < 8'h20) || b == 8'h7F;
        case (m)
            MODE_HTML_Q:
                if (b inside {"&", "<", ">", "\"", "'", 8'h0D})
                    push_text(entity_text(b));
                else
                    push_byte(b);
            MODE_HTML_U:
                // control bytes, blanks and space vanish
                if (!((b != 8'h00 && b <= 8'h20) || b == 8'h7F))
                begin
                    if (b inside {"&", "<", ">", "\"", "'", "="})
                        push_text(entity_text(b));
                    else
                        push_byte(b);
                end
            MODE_JS_Q:
                if (is_ctl || b inside {"&", "<", ">", "\"", "'", "/", "\\", ";"})
                    push_hex_escape(b);
                else
                    push_byte(b);
            MODE_JS_U:
                if (is_ctl || b inside {"&", "<", ">", "\"", "'", "/", "\\", ";", "=", " "})
                    push_hex_escape(b);
                else
                    push_byte(b);
            MODE_CSS_Q, MODE_CSS_U:
                if (is_alnum(b) || (b == " " && m == MODE_CSS_Q) || b >= 8'h80 ||
                    b inside {"_", ".", ",", "!", "#", "%", "-"})
                    push_byte(b);
            MODE_TAG:
                if (is_alnum(b) || b inside {":", "_", "-"})
                    push_byte(b);
            default:
                push_byte(b);
        endcase
        if (l)
        begin
            // a dropped last byte still leaves an end marker
            if (escaped_due.size() == first)
                escaped_due.push_back('{data: 8'h00, last: 1'b1, empty: 1'b1});
            else
            begin
                tail      = escaped_due.pop_back();
                tail.last = 1'b1;
                escaped_due.push_back(tail);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_escape(mode, in_byte, in_last);
            if (out_valid && !out_stall)
            begin
                if (escaped_due.size() == 0)
                    report_mismatch($sformatf("beat %h with nothing due", out_byte));
                else
                begin
                    seen_due = escaped_due.pop_front();
                    if (out_byte !== seen_due.data)
                        report_mismatch($sformatf("out_byte %h, due %h", out_byte, seen_due.data));
                    if (out_last !== seen_due.last)
                        report_mismatch($sformatf("out_last %b, due %b", out_last, seen_due.last));
                    if (out_empty !== seen_due.empty)
                        report_mismatch($sformatf("out_empty %b, due %b",
                                                  out_empty, seen_due.empty));
                end
            end
        end
        beats_due  <= escaped_due.size();
        fail_count <= mismatches;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import escf_pkg::*;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [2:0] mode      = MODE_HTML_Q;
    logic [7:0] in_byte   = 8'h41;
    logic       in_last   = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_empty;
    int         fail_count;
    int         beats_due;

    int    tx_idle_pct     = 0;
    int    rx_idle_pct     = 0;
    logic  long_hold_req   = 1'b0;
    logic  long_hold_taken = 1'b0;
    int    long_hold_left  = 0;
    string special_marks   = "&<>\"'=/\\;:_-.,!#% ";

    context_char_escape_filter_core u_top (.*);

    escape_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stall, or one long hold-off when asked
    always @(posedge clk)
    begin
        if (long_hold_req && !long_hold_taken)
        begin
            long_hold_taken = 1'b1;
            long_hold_left  = 120;
        end
        if (long_hold_left > 0)
        begin
            long_hold_left = long_hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    task automatic send_beat(input logic [2:0] m, input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(1, 255));
            1:       return special_marks[$urandom_range(0, special_marks.len() - 1)];
            2:       return 8'($urandom_range(1, 32));
            default: return 8'($urandom_range(8'h7E, 8'h81));
        endcase
    endfunction

    // one string in one mode, now and then a stray mode or last mark
    task automatic send_string(input int len);
        logic [2:0] str_mode;
        logic [2:0] m;
        logic       l;
        str_mode = 3'($urandom_range(MODE_HTML_Q, MODE_TAG));
        for (int i = 0; i < len; i++)
        begin
            m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(MODE_HTML_Q, MODE_TAG))
                                             : str_mode;
            l = (i == len - 1);
            if ($urandom_range(0, 9) == 0)
                l = 1'($urandom_range(0, 1));
            send_beat(m, pick_byte(), l);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input int n_items);
        int len;
        int sent;
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 8);
            send_string(len);
            sent += len;
        end
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // html quoted: entities, carriage return, plain bytes
        send_beat(MODE_HTML_Q, "&", 1'b0);
        send_beat(MODE_HTML_Q, "\"", 1'b0);
        send_beat(MODE_HTML_Q, "'", 1'b0);
        send_beat(MODE_HTML_Q, 8'h0D, 1'b0);
        send_beat(MODE_HTML_Q, 8'h01, 1'b0);
        send_beat(MODE_HTML_Q, 8'hFF, 1'b1);
        // html unquoted: equals sign, dropped space and delete, dropped last byte
        send_beat(MODE_HTML_U, "=", 1'b0);
        send_beat(MODE_HTML_U, " ", 1'b0);
        send_beat(MODE_HTML_U, 8'h7F, 1'b0);
        send_beat(MODE_HTML_U, "<", 1'b0);
        send_beat(MODE_HTML_U, 8'h01, 1'b1);
        // js: hex escapes of control bytes, metacharacters and del
        send_beat(MODE_JS_Q, 8'h01, 1'b0);
        send_beat(MODE_JS_Q, "/", 1'b0);
        send_beat(MODE_JS_Q, 8'h7F, 1'b0);
        send_beat(MODE_JS_Q, "=", 1'b1);
        send_beat(MODE_JS_U, "=", 1'b0);
        send_beat(MODE_JS_U, " ", 1'b0);
        send_beat(MODE_JS_U, "\\", 1'b1);
        // css and tag whitelists
        send_beat(MODE_CSS_Q, " ", 1'b0);
        send_beat(MODE_CSS_Q, 8'h80, 1'b0);
        send_beat(MODE_CSS_Q, "@", 1'b1);
        send_beat(MODE_CSS_U, " ", 1'b0);
        send_beat(MODE_CSS_U, "-", 1'b1);
        send_beat(MODE_TAG, ":", 1'b0);
        send_beat(MODE_TAG, 8'h80, 1'b1);
        drain_results();

        // long receiver hold-off while the sender keeps offering beats
        long_hold_req <= 1'b1;
        repeat (4) send_string(6);
        drain_results();

        random_phase(36, 86, 20);
        random_phase(86, 36, 20);
        random_phase(0, 0, 20);

        repeat (20) @(posedge clk);
        #1;
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
